>>> hw/rtl/euler_angles_to_frame_axes_macros.svh
// Assertion macros used by the checker file.
`ifndef EULER_ANGLES_TO_FRAME_AXES_MACROS_SVH
`define EULER_ANGLES_TO_FRAME_AXES_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EAFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define EAFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/eafa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eafa_pkg
// Shared constants and helpers for the Euler-angle frame axes block.
// ----------------------------------------------------------------------------
package eafa_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int COMP_W     = 16;
    localparam int IDX_W      = 3;

    // quarter-sine kernel, Q30
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam int KERNEL_STAGES = 7;
    localparam logic [31:0] SIN_COEF [6] = '{
        32'd1686629713, 32'd693598668, 32'd85569306,
        32'd5026995, 32'd172272, 32'd3864
    };

    typedef enum logic [IDX_W-1:0] {
        VEC_E1 = 3'd0,
        VEC_E2 = 3'd1,
        VEC_E3 = 3'd2,
        VEC_S1 = 3'd3,
        VEC_S2 = 3'd4
    } t_vec_idx;

    // Q30 product, truncated
    function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = {32'd0, a} * {32'd0, b};
        return pr[61:30];
    endfunction

endpackage

>>> hw/rtl/eafa_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eafa_sine
// Pipelined quarter-wave sine, odd polynomial in Q30, one multiply per stage.
// ----------------------------------------------------------------------------
module eafa_sine
    import eafa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [30:0] o_s
);

    logic [30:0] r_xd  [6];
    logic [31:0] r_x2d [6];
    logic [31:0] r_p   [6];
    logic [30:0] r_s;
    logic [31:0] n_s;

    always_comb begin
        n_s = mulq({1'b0, r_xd[5]}, r_p[5]);
        if (r_xd[5] >= Q30_ONE || n_s > {1'b0, Q30_ONE}) begin
            n_s = {1'b0, Q30_ONE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0]  <= i_x;
            r_x2d[0] <= mulq({1'b0, i_x}, {1'b0, i_x});
            r_p[0]   <= SIN_COEF[5];
            for (int j = 1; j < 6; j++) begin
                r_xd[j]  <= r_xd[j-1];
                r_x2d[j] <= r_x2d[j-1];
                r_p[j]   <= SIN_COEF[5-j] - mulq(r_x2d[j-1], r_p[j-1]);
            end
            r_s <= n_s[30:0];
        end
    end

    assign o_s = r_s;

endmodule

>>> hw/rtl/euler_angles_to_frame_axes.sv
`timescale 1ns / 1ps
// The first vector is registered into the output shift line when a request leaves the
// pipeline and the line is free; the five vectors follow in consecutive cycles when not stalled.
// The single result channel carries each angle triple as five vectors.
// The 11-stage pipeline takes a new request every cycle until results back up.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// euler_angles_to_frame_axes
// Z-Y-Z Euler angles to theta-hat, phi-hat, radial and rolled axis vectors.
// ----------------------------------------------------------------------------
module euler_angles_to_frame_axes
    import eafa_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // polar_angle[15:0], azimuth_angle[31:16], roll_angle[47:32]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // vector_index[2:0], comp_x[18:3], comp_y[34:19], comp_z[50:35], zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    localparam int W   = FRAC_BITS + 2;
    localparam int AB  = ANGLE_BITS;
    localparam int SH  = 30 - FRAC_BITS;
    localparam logic [32:0] RND = (SH == 0) ? 33'd0 : (33'd1 << ((SH > 0) ? SH - 1 : 0));
    localparam int NV  = KERNEL_STAGES + 4;
    localparam logic signed [W:0] ONE_P = (W+1)'(1) <<< FRAC_BITS;
    localparam logic signed [W:0] ONE_N = -ONE_P;

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] pr;
        logic [W-1:0]   r;
        ma = a[W-1] ? W'(-a) : W'(a);
        mb = b[W-1] ? W'(-b) : W'(b);
        pr = ((2*W)'(ma) * (2*W)'(mb) + ((2*W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        r  = pr[W-1:0];
        return (a[W-1] ^ b[W-1]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [W-1:0] to_frac(input logic [30:0] q);
        logic [32:0] v;
        v = (33'(q) + RND) >> SH;
        return $signed(v[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] sat_sum(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b,
                                                    input logic sub);
        logic signed [W:0] s;
        s = sub ? (W+1)'(a) - (W+1)'(b) : (W+1)'(a) + (W+1)'(b);
        if (s > ONE_P) begin
            s = ONE_P;
        end else if (s < ONE_N) begin
            s = ONE_N;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] fmt(input logic signed [W-1:0] v);
        logic signed [31:0] t;
        t = 32'(v);
        return t[COMP_W-1:0];
    endfunction

    logic              adv;
    logic              ser_free;
    logic [NV-1:0]     r_v;

    // stage 1: quadrant split
    logic [30:0]       r_x  [3];
    logic [30:0]       r_xc [3];
    logic [1:0]        r_qd [KERNEL_STAGES+1][3];
    logic [30:0]       k_sx [3];
    logic [30:0]       k_sc [3];

    // sin/cos stage: 0 polar, 1 azimuth, 2 roll
    logic signed [W-1:0] r_sn [3];
    logic signed [W-1:0] r_cs [3];
    logic signed [W-1:0] n_sn [3];
    logic signed [W-1:0] n_cs [3];

    // first products
    logic signed [W-1:0] r_e1 [3];
    logic signed [W-1:0] r_e2 [3];
    logic signed [W-1:0] r_e3 [3];
    logic signed [W-1:0] r_sr;
    logic signed [W-1:0] r_cr;

    // roll products
    logic signed [W-1:0] r_m1 [3];
    logic signed [W-1:0] r_m2 [3];
    logic signed [W-1:0] r_m3 [3];
    logic signed [W-1:0] r_m4 [3];
    logic signed [W-1:0] r_f1 [3];
    logic signed [W-1:0] r_f2 [3];
    logic signed [W-1:0] r_f3 [3];

    // output shift line
    logic                    r_hold_v;
    logic [IDX_W-1:0]        r_idx;
    logic [3*COMP_W-1:0]     r_vec [5];
    logic [3*COMP_W-1:0]     n_vec [5];

    assign ser_free        = !r_hold_v || (i_m_axis_tready && r_idx == VEC_S2);
    assign adv             = !r_v[NV-1] || ser_free;
    assign o_s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NV-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [AB-1:0] a;
        if (adv) begin
            for (int g = 0; g < 3; g++) begin
                a          = AB'(i_s_axis_tdata[g*16 +: 16]);
                r_x[g]     <= 31'(a[AB-3:0]) << (32 - AB);
                r_xc[g]    <= Q30_ONE - (31'(a[AB-3:0]) << (32 - AB));
                r_qd[0][g] <= a[AB-1:AB-2];
                for (int j = 1; j <= KERNEL_STAGES; j++) begin
                    r_qd[j][g] <= r_qd[j-1][g];
                end
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_trig
        eafa_sine u_sin_x (.i_clk(i_clk), .i_en(adv), .i_x(r_x[g]),  .o_s(k_sx[g]));
        eafa_sine u_sin_c (.i_clk(i_clk), .i_en(adv), .i_x(r_xc[g]), .o_s(k_sc[g]));
    end

    always_comb begin
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sc;
        for (int g = 0; g < 3; g++) begin
            sx = to_frac(k_sx[g]);
            sc = to_frac(k_sc[g]);
            case (r_qd[KERNEL_STAGES][g])
                2'd0: begin n_sn[g] = sx;  n_cs[g] = sc;  end
                2'd1: begin n_sn[g] = sc;  n_cs[g] = -sx; end
                2'd2: begin n_sn[g] = -sx; n_cs[g] = -sc; end
                default: begin n_sn[g] = -sc; n_cs[g] = sx; end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vec[0][i*COMP_W +: COMP_W] = fmt(r_f1[i]);
            n_vec[1][i*COMP_W +: COMP_W] = fmt(r_f2[i]);
            n_vec[2][i*COMP_W +: COMP_W] = fmt(r_f3[i]);
            n_vec[3][i*COMP_W +: COMP_W] = fmt(sat_sum(r_m1[i], r_m2[i], 1'b0));
            n_vec[4][i*COMP_W +: COMP_W] = fmt(sat_sum(r_m3[i], r_m4[i], 1'b1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sn <= n_sn;
            r_cs <= n_cs;

            r_e1[0] <= fmul(r_cs[0], r_cs[1]);
            r_e1[1] <= fmul(r_cs[0], r_sn[1]);
            r_e1[2] <= -r_sn[0];
            r_e2[0] <= -r_sn[1];
            r_e2[1] <= r_cs[1];
            r_e2[2] <= '0;
            r_e3[0] <= fmul(r_sn[0], r_cs[1]);
            r_e3[1] <= fmul(r_sn[0], r_sn[1]);
            r_e3[2] <= r_cs[0];
            r_sr    <= r_sn[2];
            r_cr    <= r_cs[2];

            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= fmul(r_cr, r_e1[i]);
                r_m2[i] <= fmul(r_sr, r_e2[i]);
                r_m3[i] <= fmul(r_cr, r_e2[i]);
                r_m4[i] <= fmul(r_sr, r_e1[i]);
            end
            r_f1 <= r_e1;
            r_f2 <= r_e2;
            r_f3 <= r_e3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_idx    <= VEC_E1;
        end else if (ser_free && r_v[NV-1]) begin
            r_hold_v <= 1'b1;
            r_idx    <= VEC_E1;
        end else if (r_hold_v && i_m_axis_tready) begin
            r_hold_v <= (r_idx != VEC_S2);
            r_idx    <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_free && r_v[NV-1]) begin
            r_vec <= n_vec;
        end else if (r_hold_v && i_m_axis_tready) begin
            for (int k = 0; k < 4; k++) begin
                r_vec[k] <= r_vec[k+1];
            end
        end
    end

    assign o_m_axis_tvalid = r_hold_v;
    assign o_m_axis_tlast  = (r_idx == VEC_S2);
    assign o_m_axis_tdata  = {5'd0, r_vec[0], r_idx};

endmodule

>>> hw/rtl/eafa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eafa_checker
// Port-level checks on the result stream of the frame axes block.
// ----------------------------------------------------------------------------
`include "euler_angles_to_frame_axes_macros.svh"

module eafa_checker
    import eafa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_m_valid,
    input logic                  i_m_ready,
    input logic [OUT_DATA_W-1:0] i_m_data,
    input logic                  i_m_last
);

    `EAFA_ASSERT_NOW(a_last_on_s2, i_clk, i_rst_n, i_m_valid, i_m_last == (i_m_data[2:0] == VEC_S2))
    `EAFA_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, i_m_valid, i_m_data[2:0] <= VEC_S2)
    `EAFA_ASSERT_NEXT(a_run_unbroken, i_clk, i_rst_n, i_m_valid && i_m_ready && !i_m_last, i_m_valid && i_m_data[2:0] == $past(i_m_data[2:0]) + 3'd1)
    `EAFA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_m_valid && !i_m_ready, i_m_valid && $stable(i_m_data))

endmodule

bind euler_angles_to_frame_axes eafa_checker u_eafa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_valid (o_m_axis_tvalid),
    .i_m_ready (i_m_axis_tready),
    .i_m_data  (o_m_axis_tdata),
    .i_m_last  (o_m_axis_tlast)
);
